// ===== src/register_write_packet_framer_defines.svh =====
// Assertion macros shared by the register write packet framer RTL.
// Depends on nothing; each user supplies clk and rst_n in scope.
`ifndef REGISTER_WRITE_PACKET_FRAMER_DEFINES_SVH
`define REGISTER_WRITE_PACKET_FRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RWPF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwpf implication check failed");

// Next-cycle implication, checked out of reset.
`define RWPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwpf next-cycle check failed");

`endif

// ===== src/rwpf_pkg.sv =====
// Shared types, codes and helpers for the register write packet framer.
// Depends on nothing; used by rwpf_byte_ser and register_write_packet_framer.
package rwpf_pkg;

    localparam int FRAME_MAX = 8;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);

    // item kind carried in the input tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // configuration register indexes
    localparam logic REG_IO_CMD   = 1'b0;
    localparam logic REG_ADDR_CMD = 1'b1;

    // size codes in the low bits of command bytes
    localparam logic [1:0] SZ_ADDR   = 2'd2;
    localparam logic [1:0] SZ_LEN    = 2'd1;
    localparam logic [1:0] SZ_CHUNK4 = 2'd3;
    localparam logic [1:0] SZ_CHUNK2 = 2'd2;
    localparam logic [1:0] SZ_CHUNK1 = 2'd1;

    typedef struct packed {
        logic [7:0] data;
        logic       cmd;
        logic       last;
    } byte_ent_t;

    typedef struct packed {
        logic [CNT_W-1:0]               count;
        byte_ent_t [FRAME_MAX-1:0]      ent;
    } frame_t;

    function automatic logic [7:0] cmd_byte(input logic [7:0] base, input logic [1:0] sel,
                                            input logic [1:0] code);
        return base | {4'b0000, sel, code};
    endfunction

endpackage

// ===== src/register_write_packet_framer.sv =====
// Register write packet framer, top level.
// Depends on rwpf_pkg, rwpf_byte_ser and register_write_packet_framer_defines.svh.
//
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------------------
// s_axis    | in        | tvalid/tready          | tuser {target_select, mode}, tdata 64 bits
// m_axis    | out       | tvalid/tready          | tdata out_byte, tuser is_command, tlast end
// cfg       | in        | cfg_we (no wait)       | cfg_index, cfg_data 8 bits
//
// A start beat yields 5 output beats (zero count) or 8; a data beat inside a packet
// yields 3 beats when it opens a chunk and 2 otherwise; a data beat outside a packet
// yields none and is absorbed once the output buffer is free. The rate is set by the one-byte output
// link: the next input beat is taken in the cycle the last byte of the previous one
// leaves, so a new item is not taken while bytes of the previous one remain.
// Reset clears the packet state, the command bases and the output byte count (not the held bytes); no sweep.
// A stall on m_axis holds the buffered bytes and backs up into s_axis tready.
`include "register_write_packet_framer_defines.svh"

module register_write_packet_framer
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] start_address, [47:32] word_count,
                                        // [63:48] data_word
    input  logic [2:0]  s_axis_tuser,   // [0] mode, [2:1] target_select
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] is_command
    output logic        m_axis_tlast,   // packet_end
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    // input field split
    logic        mode;
    logic [1:0]  target_select;
    logic [31:0] start_address;
    logic [15:0] word_count;
    logic [15:0] data_word;

    assign mode          = s_axis_tuser[0];
    assign target_select = s_axis_tuser[2:1];
    assign start_address = s_axis_tdata[31:0];
    assign word_count    = s_axis_tdata[47:32];
    assign data_word     = s_axis_tdata[63:48];

    // command bases
    logic [7:0] io_cmd_reg;
    logic [7:0] addr_cmd_reg;

    // packet state
    logic [15:0] words_left_reg;
    logic [15:0] words_left_next;
    logic [2:0]  chunk_left_reg;
    logic [2:0]  chunk_left_next;
    logic [1:0]  held_select_reg;
    logic [1:0]  held_select_next;
    logic        packet_open_reg;
    logic        packet_open_next;

    rwpf_pkg::frame_t    frame;
    rwpf_pkg::byte_ent_t out_ent;
    logic                accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Build the whole byte list for the current input beat and the state it leaves.
    always_comb
    begin
        logic       no_data;
        logic [1:0] code;
        logic [2:0] size;

        no_data          = (word_count == 16'd0);
        code             = rwpf_pkg::SZ_CHUNK1;
        size             = 3'd1;
        frame            = '0;
        words_left_next  = words_left_reg;
        chunk_left_next  = chunk_left_reg;
        held_select_next = held_select_reg;
        packet_open_next = packet_open_reg;

        if (mode == rwpf_pkg::MODE_START)
        begin
            // address command and four address bytes, MSB first
            held_select_next   = target_select;
            frame.ent[0].data  = rwpf_pkg::cmd_byte(addr_cmd_reg, target_select,
                                                    rwpf_pkg::SZ_ADDR);
            frame.ent[0].cmd   = 1'b1;
            frame.ent[1].data  = start_address[31:24];
            frame.ent[2].data  = start_address[23:16];
            frame.ent[3].data  = start_address[15:8];
            frame.ent[4].data  = start_address[7:0];
            frame.ent[4].last  = no_data;
            chunk_left_next    = 3'd0;
            if (no_data)
            begin
                frame.count      = rwpf_pkg::CNT_W'(5);
                packet_open_next = 1'b0;
                words_left_next  = 16'd0;
            end
            else
            begin
                // length command and the count, high byte first
                frame.count       = rwpf_pkg::CNT_W'(8);
                frame.ent[5].data = rwpf_pkg::cmd_byte(io_cmd_reg, target_select,
                                                       rwpf_pkg::SZ_LEN);
                frame.ent[5].cmd  = 1'b1;
                frame.ent[6].data = word_count[15:8];
                frame.ent[7].data = word_count[7:0];
                packet_open_next  = 1'b1;
                words_left_next   = word_count;
            end
        end
        else if (!packet_open_reg || (words_left_reg == 16'd0))
        begin
            // drop stray data
            frame.count      = '0;
            packet_open_next = 1'b0;
        end
        else
        begin
            if (words_left_reg >= 16'd4)
            begin
                code = rwpf_pkg::SZ_CHUNK4;
                size = 3'd4;
            end
            else if (words_left_reg >= 16'd2)
            begin
                code = rwpf_pkg::SZ_CHUNK2;
                size = 3'd2;
            end

            if (chunk_left_reg == 3'd0)
            begin
                // open a chunk ahead of the word
                frame.count       = rwpf_pkg::CNT_W'(3);
                frame.ent[0].data = rwpf_pkg::cmd_byte(io_cmd_reg, held_select_reg, code);
                frame.ent[0].cmd  = 1'b1;
                frame.ent[1].data = data_word[15:8];
                frame.ent[2].data = data_word[7:0];
                frame.ent[2].last = (words_left_reg == 16'd1);
                chunk_left_next   = size - 3'd1;
            end
            else
            begin
                frame.count       = rwpf_pkg::CNT_W'(2);
                frame.ent[0].data = data_word[15:8];
                frame.ent[1].data = data_word[7:0];
                frame.ent[1].last = (words_left_reg == 16'd1);
                chunk_left_next   = chunk_left_reg - 3'd1;
            end

            words_left_next = words_left_reg - 16'd1;
            if (words_left_reg == 16'd1)
            begin
                packet_open_next = 1'b0;
                chunk_left_next  = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_cmd_reg      <= 8'd0;
            addr_cmd_reg    <= 8'd0;
            words_left_reg  <= 16'd0;
            chunk_left_reg  <= 3'd0;
            held_select_reg <= 2'd0;
            packet_open_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rwpf_pkg::REG_IO_CMD:   io_cmd_reg   <= cfg_data;
                    rwpf_pkg::REG_ADDR_CMD: addr_cmd_reg <= cfg_data;
                    default:                io_cmd_reg   <= io_cmd_reg;
                endcase
            end
            if (accept)
            begin
                words_left_reg  <= words_left_next;
                chunk_left_reg  <= chunk_left_next;
                held_select_reg <= held_select_next;
                packet_open_reg <= packet_open_next;
            end
        end
    end

    // Output buffer: takes a built frame and plays it out a beat at a time.
    rwpf_byte_ser u_ser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame),
        .load_valid (s_axis_tvalid),
        .load_ready (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_ent    (out_ent)
    );

    assign m_axis_tdata = out_ent.data;
    assign m_axis_tuser = out_ent.cmd;
    assign m_axis_tlast = out_ent.last;

    `RWPF_ASSERT_IMPL(a_open_has_words, packet_open_reg, words_left_reg != 16'd0)
    `RWPF_ASSERT_IMPL(a_closed_no_chunk, !packet_open_reg, chunk_left_reg == 3'd0)
    `RWPF_ASSERT_IMPL(a_chunk_bound, 1'b1, chunk_left_reg <= 3'd3)

endmodule

// ===== src/rwpf_byte_ser.sv =====
// Byte serializer: holds one item's framed bytes and hands them out one beat each.
// Depends on rwpf_pkg and register_write_packet_framer_defines.svh.
`include "register_write_packet_framer_defines.svh"

module rwpf_byte_ser
(
    input  logic               clk,
    input  logic               rst_n,
    input  rwpf_pkg::frame_t   frame_in,
    input  logic               load_valid,
    output logic               load_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output rwpf_pkg::byte_ent_t out_ent
);

    rwpf_pkg::byte_ent_t [rwpf_pkg::FRAME_MAX-1:0] buf_reg;
    rwpf_pkg::byte_ent_t [rwpf_pkg::FRAME_MAX-1:0] buf_next;
    logic [rwpf_pkg::CNT_W-1:0] rem_reg;
    logic [rwpf_pkg::CNT_W-1:0] rem_next;
    logic take;
    logic load;

    assign out_valid  = (rem_reg != '0);
    assign out_ent    = buf_reg[0];
    assign take       = out_valid && out_ready;
    // free when empty, or when the last held byte leaves this cycle
    assign load_ready = (rem_reg == '0) ||
                        ((rem_reg == rwpf_pkg::CNT_W'(1)) && take);
    assign load       = load_valid && load_ready;

    always_comb
    begin
        buf_next = buf_reg;
        rem_next = rem_reg;
        if (load)
        begin
            buf_next = frame_in.ent;
            rem_next = frame_in.count;
        end
        else if (take)
        begin
            // advance: next byte moves to the head
            for (int i = 0; i < rwpf_pkg::FRAME_MAX - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
            rem_next = rem_reg - rwpf_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    `RWPF_ASSERT_NEXT(a_load_count, load, rem_reg == $past(frame_in.count))
    `RWPF_ASSERT_NEXT(a_take_count, take && !load, rem_reg == $past(rem_reg) - rwpf_pkg::CNT_W'(1))
    `RWPF_ASSERT_IMPL(a_rem_bound, 1'b1, rem_reg <= rwpf_pkg::CNT_W'(rwpf_pkg::FRAME_MAX))

endmodule
